>>> design/gsv_pkg.sv
// Shared types and codes for the GIF structure validator.
package gsv_pkg;

   localparam logic [1:0] VERDICT_BUSY  = 2'd0;
   localparam logic [1:0] VERDICT_OK    = 2'd1;
   localparam logic [1:0] VERDICT_ERROR = 2'd2;

   localparam logic [2:0] FAULT_NONE  = 3'd0;
   localparam logic [2:0] FAULT_SIG   = 3'd1;
   localparam logic [2:0] FAULT_MARK  = 3'd2;
   localparam logic [2:0] FAULT_SIZE  = 3'd3;
   localparam logic [2:0] FAULT_EARLY = 3'd4;
   localparam logic [2:0] FAULT_AFTER = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } gsv_req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [2:0] fault_kind;
      logic       is_version_89a;
   } gsv_rsp_type;

endpackage

>>> design/gsv_parser.sv
// Per-byte GIF block parser: parse state registers and next-state logic.
module gsv_parser
   import gsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  gsv_req_type byte_in,
   output gsv_rsp_type result
);

   typedef enum logic [4:0] {
      PH_SIG       = 5'd0,
      PH_LSD       = 5'd1,
      PH_GCT       = 5'd2,
      PH_E87       = 5'd3,
      PH_E89_FIRST = 5'd4,
      PH_LABEL_1ST = 5'd5,
      PH_LABEL     = 5'd6,
      PH_AFTER_EXT = 5'd7,
      PH_AFTER_GI  = 5'd8,
      PH_GCE_SIZE  = 5'd9,
      PH_GCE_BODY  = 5'd10,
      PH_GCE_TERM  = 5'd11,
      PH_APP_SIZE  = 5'd12,
      PH_PT_SIZE   = 5'd13,
      PH_APP_SKIP  = 5'd14,
      PH_PT_SKIP   = 5'd15,
      PH_CHX_SIZE  = 5'd16,
      PH_CHX_DATA  = 5'd17,
      PH_CHT_SIZE  = 5'd18,
      PH_CHT_DATA  = 5'd19,
      PH_IMG_DESC  = 5'd20,
      PH_LCT       = 5'd21,
      PH_LZW_SIZE  = 5'd22,
      PH_DONE      = 5'd23
   } phase_type;

   localparam logic [7:0] TRAILER     = 8'h3b;
   localparam logic [7:0] IMAGE_SEP   = 8'h2c;
   localparam logic [7:0] EXT_INTRO   = 8'h21;
   localparam logic [7:0] LABEL_GCE   = 8'hf9;
   localparam logic [7:0] LABEL_CMT   = 8'hfe;
   localparam logic [7:0] LABEL_PT    = 8'h01;
   localparam logic [7:0] LABEL_APP   = 8'hff;
   localparam logic [7:0] SIZE_GCE    = 8'h04;
   localparam logic [7:0] SIZE_APP    = 8'h0b;
   localparam logic [7:0] SIZE_PT     = 8'h0c;
   localparam logic [7:0] CHAR_7      = 8'h37;
   localparam logic [7:0] CHAR_9      = 8'h39;

   function automatic logic [7:0] sig_char(input logic [2:0] idx);
      case (idx)
         3'd0:    sig_char = 8'h47;
         3'd1:    sig_char = 8'h49;
         3'd2:    sig_char = 8'h46;
         3'd3:    sig_char = 8'h38;
         3'd4:    sig_char = CHAR_7;
         3'd5:    sig_char = 8'h61;
         default: sig_char = 8'h00;
      endcase
   endfunction

   // color table length: 3 << (size field + 1)
   function automatic logic [9:0] table_len(input logic [7:0] packed_byte);
      table_len = 10'd3 << ({1'b0, packed_byte[2:0]} + 4'd1);
   endfunction

   phase_type  phase_ff, phase_in, phase_step;
   logic [9:0] count_ff, count_in, count_step;
   logic [7:0] left_ff, left_in, left_step;
   logic       ver_ff, ver_in, ver_step;
   logic       app_ff, app_in, app_step;
   logic [7:0] latch_ff, latch_in, latch_step;
   logic [2:0] fault_ff, fault_in, fault_step, fault_cur;
   logic [7:0] b;
   logic [9:0] count_dec;
   logic [7:0] left_dec;
   logic       label_first;

   assign b         = byte_in.data_byte;
   assign count_dec = count_ff - 10'd1;
   assign left_dec  = left_ff - 8'd1;

   always_comb begin
      phase_step  = phase_ff;
      count_step  = count_ff;
      left_step   = left_ff;
      ver_step    = ver_ff;
      app_step    = app_ff;
      latch_step  = latch_ff;
      fault_step  = FAULT_NONE;
      label_first = (phase_ff == PH_LABEL_1ST);
      case (phase_ff)
         PH_SIG: begin
            if (count_ff[2:0] == 3'd4 && b == CHAR_9) begin
               ver_step = 1'b1;
            end else if (b != sig_char(count_ff[2:0])) begin
               fault_step = FAULT_SIG;
            end
            count_step = count_ff + 10'd1;
            if (count_ff >= 10'd5) phase_step = PH_LSD;
         end
         PH_LSD: begin
            if (count_ff == 10'd10) latch_step = b;
            if (count_ff >= 10'd12) begin
               if (latch_ff[7]) begin
                  count_step = table_len(latch_ff);
                  phase_step = PH_GCT;
               end else begin
                  phase_step = ver_ff ? PH_E89_FIRST : PH_E87;
               end
            end else begin
               count_step = count_ff + 10'd1;
            end
         end
         PH_GCT: begin
            count_step = count_dec;
            if (count_dec == 10'd0) phase_step = ver_ff ? PH_E89_FIRST : PH_E87;
         end
         PH_E87: begin
            if (b == IMAGE_SEP) begin
               phase_step = PH_IMG_DESC;
               count_step = 10'd1;
            end else begin
               fault_step = FAULT_MARK;
            end
         end
         PH_E89_FIRST, PH_AFTER_EXT: begin
            if (b == EXT_INTRO) begin
               phase_step = (phase_ff == PH_E89_FIRST) ? PH_LABEL_1ST : PH_LABEL;
            end else if (b == IMAGE_SEP) begin
               phase_step = PH_IMG_DESC;
               count_step = 10'd1;
            end else begin
               fault_step = FAULT_MARK;
            end
         end
         PH_LABEL_1ST, PH_LABEL: begin
            if (b == LABEL_GCE) begin
               phase_step = PH_GCE_SIZE;
            end else if (b == LABEL_CMT) begin
               phase_step = PH_CHX_SIZE;
            end else if (b == LABEL_PT) begin
               phase_step = PH_PT_SIZE;
            end else if (b == LABEL_APP && label_first) begin
               phase_step = PH_APP_SIZE;
               app_step   = 1'b1;
            end else begin
               fault_step = FAULT_MARK;
            end
         end
         PH_AFTER_GI: begin
            if (b == EXT_INTRO && app_ff) begin
               phase_step = PH_LABEL;
            end else if (b == TRAILER) begin
               phase_step = PH_DONE;
            end else begin
               fault_step = FAULT_MARK;
            end
         end
         PH_GCE_SIZE: begin
            if (b != SIZE_GCE) fault_step = FAULT_SIZE;
            count_step = 10'd4;
            phase_step = PH_GCE_BODY;
         end
         PH_GCE_BODY: begin
            count_step = count_dec;
            if (count_dec == 10'd0) phase_step = PH_GCE_TERM;
         end
         PH_GCE_TERM: begin
            if (b != 8'd0) fault_step = FAULT_SIZE;
            phase_step = PH_AFTER_EXT;
         end
         PH_APP_SIZE: begin
            if (b != SIZE_APP) fault_step = FAULT_SIZE;
            count_step = {2'b00, SIZE_APP};
            phase_step = PH_APP_SKIP;
         end
         PH_PT_SIZE: begin
            if (b != SIZE_PT) fault_step = FAULT_SIZE;
            count_step = {2'b00, SIZE_PT};
            phase_step = PH_PT_SKIP;
         end
         PH_APP_SKIP: begin
            count_step = count_dec;
            if (count_dec == 10'd0) phase_step = PH_CHT_SIZE;
         end
         PH_PT_SKIP: begin
            count_step = count_dec;
            if (count_dec == 10'd0) phase_step = PH_CHX_SIZE;
         end
         PH_CHX_SIZE: begin
            if (b == 8'd0) begin
               phase_step = PH_AFTER_EXT;
            end else begin
               left_step  = b;
               phase_step = PH_CHX_DATA;
            end
         end
         PH_CHT_SIZE: begin
            if (b == 8'd0) begin
               phase_step = PH_AFTER_GI;
            end else begin
               left_step  = b;
               phase_step = PH_CHT_DATA;
            end
         end
         PH_CHX_DATA: begin
            left_step = left_dec;
            if (left_dec == 8'd0) phase_step = PH_CHX_SIZE;
         end
         PH_CHT_DATA: begin
            left_step = left_dec;
            if (left_dec == 8'd0) phase_step = PH_CHT_SIZE;
         end
         PH_IMG_DESC: begin
            if (count_ff >= 10'd9) begin
               latch_step = b;
               if (b[7]) begin
                  count_step = table_len(b);
                  phase_step = PH_LCT;
               end else begin
                  phase_step = PH_LZW_SIZE;
               end
            end else begin
               count_step = count_ff + 10'd1;
            end
         end
         PH_LCT: begin
            count_step = count_dec;
            if (count_dec == 10'd0) phase_step = PH_LZW_SIZE;
         end
         PH_LZW_SIZE: begin
            phase_step = PH_CHT_SIZE;
         end
         PH_DONE: begin
            fault_step = FAULT_AFTER;
         end
         default: begin
            fault_step = FAULT_MARK;
         end
      endcase
   end

   // a held fault freezes parsing; a new fault leaves the parse state as it was
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      left_in  = left_ff;
      ver_in   = ver_ff;
      app_in   = app_ff;
      latch_in = latch_ff;
      fault_in = fault_ff;
      if (fault_ff == FAULT_NONE) begin
         if (fault_step == FAULT_NONE) begin
            phase_in = phase_step;
            count_in = count_step;
            left_in  = left_step;
            ver_in   = ver_step;
            app_in   = app_step;
            latch_in = latch_step;
         end else begin
            fault_in = fault_step;
         end
      end
      fault_cur = fault_in;
      if (byte_in.last_byte && fault_in == FAULT_NONE && phase_in != PH_DONE) begin
         fault_cur = FAULT_EARLY;
      end
      result.fault_kind     = fault_cur;
      result.is_version_89a = ver_in;
      if (fault_cur != FAULT_NONE) begin
         result.verdict = VERDICT_ERROR;
      end else if (byte_in.last_byte) begin
         result.verdict = VERDICT_OK;
      end else begin
         result.verdict = VERDICT_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && byte_in.last_byte)) begin
         phase_ff <= PH_SIG;
         count_ff <= 10'd0;
         left_ff  <= 8'd0;
         ver_ff   <= 1'b0;
         app_ff   <= 1'b0;
         latch_ff <= 8'd0;
         fault_ff <= FAULT_NONE;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         ver_ff   <= ver_in;
         app_ff   <= app_in;
         latch_ff <= latch_in;
         fault_ff <= fault_in;
      end
   end

endmodule

>>> design/gif_structure_validator.sv
// Top level of the GIF structure validator: input register, parser, result register.
// A byte goes from the input register through the parser into the result register; a
// stall on the result side can hold it in the input register.
// Throughput: one byte per cycle while the result side does not stall; the parse state updates once per byte.
// Stalls on the result side back up through the input register only.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the first signature byte; the parser also resets after a final byte.
module gif_structure_validator
   import gsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gsv_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gsv_rsp_type rsp_payload
);

   logic        in_valid_ff;
   gsv_req_type in_data_ff;
   logic        rsp_valid_ff;
   gsv_rsp_type rsp_data_ff;
   gsv_rsp_type step_result;
   logic        advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   gsv_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .byte_in (in_data_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_payload;
      if (advance) rsp_data_ff <= step_result;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

>>> design/gsv_checker.sv
// Port-level assertions for the GIF structure validator, bound to the top level.
module gsv_checker
   import gsv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input gsv_rsp_type rsp_payload
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result transaction changed");

   // accepted verdict never carries a fault code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.verdict == VERDICT_OK |-> rsp_payload.fault_kind == FAULT_NONE)
      else $error("accept verdict with a fault");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.verdict == VERDICT_ERROR) ==
                     (rsp_payload.fault_kind != FAULT_NONE)))
      else $error("error verdict and fault code disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.fault_kind <= FAULT_AFTER && rsp_payload.verdict != 2'd3)
      else $error("result code out of range");

endmodule

bind gif_structure_validator gsv_checker u_gsv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> tb/gif_format_pkg.sv
// GIF byte values shared by the stimulus generator and the checker.
package gif_format_pkg;

   // "GIF87a"; byte 4 is the version digit
   localparam logic [47:0] SIG_GIF87A = 48'h474946383761;
   localparam logic [7:0]  VER_87 = 8'h37;
   localparam logic [7:0]  VER_89 = 8'h39;

   localparam logic [7:0] EXT_INTRO        = 8'h21;
   localparam logic [7:0] IMAGE_SEP        = 8'h2c;
   localparam logic [7:0] TRAILER          = 8'h3b;
   localparam logic [7:0] LABEL_GFX_CTRL   = 8'hf9;
   localparam logic [7:0] LABEL_COMMENT    = 8'hfe;
   localparam logic [7:0] LABEL_PLAIN_TEXT = 8'h01;
   localparam logic [7:0] LABEL_APP        = 8'hff;
   localparam logic [7:0] GFX_CTRL_LEN     = 8'h04;
   localparam logic [7:0] APP_LEN          = 8'h0b;
   localparam logic [7:0] PLAIN_TEXT_LEN   = 8'h0c;
   localparam logic [7:0] BLOCK_END        = 8'h00;

endpackage

>>> tb/gsv_checker.sv
// Checker: tracks GIF parse state per byte transaction and compares every result.
module gsv_tb_checker
   import gsv_pkg::*;
   import gif_format_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  gsv_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  gsv_rsp_type rsp_payload,
   output int          mismatch_count,
   output int          results_pending
);

   typedef enum logic [4:0] {
      ST_SIG, ST_SCREEN, ST_GLOBAL_TBL, ST_BLOCK_87, ST_BLOCK_89_FIRST,
      ST_LABEL_FIRST, ST_LABEL, ST_AFTER_EXT, ST_AFTER_IMAGE,
      ST_GCE_SIZE, ST_GCE_BODY, ST_GCE_TERM, ST_APP_SIZE, ST_PT_SIZE,
      ST_APP_SKIP, ST_PT_SKIP, ST_EXT_SUB_SIZE, ST_EXT_SUB_DATA,
      ST_IMG_SUB_SIZE, ST_IMG_SUB_DATA, ST_IMG_DESC, ST_LOCAL_TBL,
      ST_CODE_SIZE, ST_TRAILER_SEEN
   } parse_state_type;

   parse_state_type phase;
   logic [9:0]   field_cnt;
   logic [7:0]   sub_left;
   logic         version_89a;
   logic         app_path;
   logic [7:0]   tbl_flags;
   logic [2:0]   fault_held;

   gsv_rsp_type  expected_results[$];

   function automatic void clear_parser();
      phase       = ST_SIG;
      field_cnt   = '0;
      sub_left    = '0;
      version_89a = 1'b0;
      app_path    = 1'b0;
      tbl_flags   = '0;
      fault_held  = FAULT_NONE;
   endfunction

   function automatic void raise_fault(logic [2:0] kind);
      if (fault_held == FAULT_NONE) fault_held = kind;
   endfunction

   function automatic logic [9:0] color_table_len(logic [7:0] flags);
      return 10'd3 << (int'(flags[2:0]) + 1);
   endfunction

   function automatic void start_image();
      phase     = ST_IMG_DESC;
      field_cnt = 10'd1;
   endfunction

   function automatic void enter_blocks();
      phase = version_89a ? ST_BLOCK_89_FIRST : ST_BLOCK_87;
   endfunction

   // application extension is only legal as the very first block
   function automatic void take_label(logic [7:0] b, logic app_ok);
      if (b == LABEL_GFX_CTRL) phase = ST_GCE_SIZE;
      else if (b == LABEL_COMMENT) phase = ST_EXT_SUB_SIZE;
      else if (b == LABEL_PLAIN_TEXT) phase = ST_PT_SIZE;
      else if (b == LABEL_APP && app_ok) begin
         phase    = ST_APP_SIZE;
         app_path = 1'b1;
      end
      else raise_fault(FAULT_MARK);
   endfunction

   function automatic void parse_gif_byte(logic [7:0] b);
      case (phase)
         ST_SIG: begin
            if (field_cnt == 10'd4 && b == VER_89) version_89a = 1'b1;
            else if (b != SIG_GIF87A[8*(5 - int'(field_cnt)) +: 8]) raise_fault(FAULT_SIG);
            if (fault_held == FAULT_NONE) begin
               field_cnt++;
               if (field_cnt >= 10'd6) phase = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            if (field_cnt == 10'd10) tbl_flags = b;
            if (field_cnt >= 10'd12) begin
               if (tbl_flags[7]) begin
                  field_cnt = color_table_len(tbl_flags);
                  phase     = ST_GLOBAL_TBL;
               end
               else enter_blocks();
            end
            else field_cnt++;
         end
         ST_GLOBAL_TBL: begin
            field_cnt--;
            if (field_cnt == '0) enter_blocks();
         end
         ST_BLOCK_87: begin
            if (b == IMAGE_SEP) start_image();
            else raise_fault(FAULT_MARK);
         end
         ST_BLOCK_89_FIRST, ST_AFTER_EXT: begin
            if (b == EXT_INTRO) phase = (phase == ST_AFTER_EXT) ? ST_LABEL : ST_LABEL_FIRST;
            else if (b == IMAGE_SEP) start_image();
            else raise_fault(FAULT_MARK);
         end
         ST_LABEL_FIRST: take_label(b, 1'b1);
         ST_LABEL:       take_label(b, 1'b0);
         ST_AFTER_IMAGE: begin
            if (b == EXT_INTRO && app_path) phase = ST_LABEL;
            else if (b == TRAILER) phase = ST_TRAILER_SEEN;
            else raise_fault(FAULT_MARK);
         end
         ST_GCE_SIZE: begin
            if (b != GFX_CTRL_LEN) raise_fault(FAULT_SIZE);
            else begin
               field_cnt = 10'd4;
               phase     = ST_GCE_BODY;
            end
         end
         ST_GCE_BODY: begin
            field_cnt--;
            if (field_cnt == '0) phase = ST_GCE_TERM;
         end
         ST_GCE_TERM: begin
            if (b != BLOCK_END) raise_fault(FAULT_SIZE);
            else phase = ST_AFTER_EXT;
         end
         ST_APP_SIZE: begin
            if (b != APP_LEN) raise_fault(FAULT_SIZE);
            else begin
               field_cnt = 10'(APP_LEN);
               phase     = ST_APP_SKIP;
            end
         end
         ST_PT_SIZE: begin
            if (b != PLAIN_TEXT_LEN) raise_fault(FAULT_SIZE);
            else begin
               field_cnt = 10'(PLAIN_TEXT_LEN);
               phase     = ST_PT_SKIP;
            end
         end
         ST_APP_SKIP: begin
            field_cnt--;
            if (field_cnt == '0) phase = ST_IMG_SUB_SIZE;
         end
         ST_PT_SKIP: begin
            field_cnt--;
            if (field_cnt == '0) phase = ST_EXT_SUB_SIZE;
         end
         ST_EXT_SUB_SIZE: begin
            if (b == BLOCK_END) phase = ST_AFTER_EXT;
            else begin
               sub_left = b;
               phase    = ST_EXT_SUB_DATA;
            end
         end
         ST_EXT_SUB_DATA: begin
            sub_left--;
            if (sub_left == '0) phase = ST_EXT_SUB_SIZE;
         end
         ST_IMG_SUB_SIZE: begin
            if (b == BLOCK_END) phase = ST_AFTER_IMAGE;
            else begin
               sub_left = b;
               phase    = ST_IMG_SUB_DATA;
            end
         end
         ST_IMG_SUB_DATA: begin
            sub_left--;
            if (sub_left == '0) phase = ST_IMG_SUB_SIZE;
         end
         ST_IMG_DESC: begin
            if (field_cnt >= 10'd9) begin
               tbl_flags = b;
               if (b[7]) begin
                  field_cnt = color_table_len(b);
                  phase     = ST_LOCAL_TBL;
               end
               else phase = ST_CODE_SIZE;
            end
            else field_cnt++;
         end
         ST_LOCAL_TBL: begin
            field_cnt--;
            if (field_cnt == '0) phase = ST_CODE_SIZE;
         end
         ST_CODE_SIZE:    phase = ST_IMG_SUB_SIZE;
         ST_TRAILER_SEEN: raise_fault(FAULT_AFTER);
         default:         raise_fault(FAULT_MARK);
      endcase
   endfunction

   function automatic gsv_rsp_type predict_verdict(gsv_req_type req);
      gsv_rsp_type r;
      if (fault_held == FAULT_NONE) parse_gif_byte(req.data_byte);
      if (req.last_byte && fault_held == FAULT_NONE && phase != ST_TRAILER_SEEN)
         raise_fault(FAULT_EARLY);
      if (fault_held != FAULT_NONE) r.verdict = VERDICT_ERROR;
      else r.verdict = req.last_byte ? VERDICT_OK : VERDICT_BUSY;
      r.fault_kind     = fault_held;
      r.is_version_89a = version_89a;
      // every file starts from scratch after its final byte
      if (req.last_byte) clear_parser();
      return r;
   endfunction

   function automatic void report_mismatch(string what, gsv_rsp_type want, gsv_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: exp verdict=%0d fault=%0d v89a=%0d, %s=%0d fault=%0d v89a=%0d",
                  $time, what, want.verdict, want.fault_kind, want.is_version_89a,
                  "got verdict", got.verdict, got.fault_kind, got.is_version_89a);
   endfunction

   always @(posedge clock) begin
      gsv_rsp_type want;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               want = '0;
               report_mismatch("result with no transaction pending", want, rsp_payload);
            end else begin
               want = expected_results.pop_front();
               if (want.verdict !== rsp_payload.verdict ||
                   want.fault_kind !== rsp_payload.fault_kind ||
                   want.is_version_89a !== rsp_payload.is_version_89a)
                  report_mismatch("result mismatch", want, rsp_payload);
            end
         end
         if (req_valid && req_ready) expected_results.push_back(predict_verdict(req_payload));
      end
      results_pending = expected_results.size();
   end

endmodule

>>> tb/gif_structure_validator_tb.sv
// Testbench top: builds GIF byte streams, drives both channels and reports the verdict.
module gif_structure_validator_tb;
   import gsv_pkg::*;
   import gif_format_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_START   = 300;
   localparam int HOLD_CYCLES  = 120;

   typedef enum logic [1:0] { EXT_GFX_CTRL, EXT_COMMENT, EXT_PLAIN_TEXT } ext_kind_type;
   typedef enum logic [1:0] {
      LAYOUT_IMAGE_ONLY, LAYOUT_EXT_IMAGE, LAYOUT_APP_GROUPS
   } layout_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   gsv_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   gsv_rsp_type rsp_payload;
   logic        idle_on;
   int          mismatch_count;
   int          results_pending;

   logic [7:0]  gif_bytes[$];
   int          label_spots[$];
   int          size_spots[$];

   gif_structure_validator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   gsv_tb_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------- GIF stream generation ----------------

   function automatic void put_random(int n);
      repeat (n) gif_bytes.push_back(8'($urandom));
   endfunction

   function automatic void put_signature(logic [7:0] ver, int n);
      for (int i = 0; i < n; i++)
         gif_bytes.push_back(i == 4 ? ver : SIG_GIF87A[8*(5 - i) +: 8]);
   endfunction

   // mostly tiny tables; the 768-byte one only now and then
   function automatic logic [7:0] pick_table_flags();
      logic [2:0] sz;
      sz = ($urandom_range(59) == 0) ? 3'd7 : 3'($urandom_range(1));
      return {1'($urandom_range(1)), 4'($urandom), sz};
   endfunction

   function automatic void put_color_table(logic [7:0] flags);
      if (flags[7]) put_random(3 << (int'(flags[2:0]) + 1));
   endfunction

   function automatic void put_subblocks();
      int len;
      repeat ($urandom_range(2)) begin
         len = ($urandom_range(59) == 0) ? 255 : $urandom_range(1, 4);
         gif_bytes.push_back(8'(len));
         put_random(len);
      end
      gif_bytes.push_back(BLOCK_END);
   endfunction

   function automatic void put_extension();
      gif_bytes.push_back(EXT_INTRO);
      label_spots.push_back(gif_bytes.size());
      case (ext_kind_type'($urandom_range(2)))
         EXT_GFX_CTRL: begin
            gif_bytes.push_back(LABEL_GFX_CTRL);
            size_spots.push_back(gif_bytes.size());
            gif_bytes.push_back(GFX_CTRL_LEN);
            put_random(4);
            size_spots.push_back(gif_bytes.size());
            gif_bytes.push_back(BLOCK_END);
         end
         EXT_COMMENT: begin
            gif_bytes.push_back(LABEL_COMMENT);
            put_subblocks();
         end
         default: begin
            gif_bytes.push_back(LABEL_PLAIN_TEXT);
            size_spots.push_back(gif_bytes.size());
            gif_bytes.push_back(PLAIN_TEXT_LEN);
            put_random(int'(PLAIN_TEXT_LEN));
            put_subblocks();
         end
      endcase
   endfunction

   function automatic void put_app_extension();
      gif_bytes.push_back(EXT_INTRO);
      label_spots.push_back(gif_bytes.size());
      gif_bytes.push_back(LABEL_APP);
      size_spots.push_back(gif_bytes.size());
      gif_bytes.push_back(APP_LEN);
      put_random(int'(APP_LEN));
      put_subblocks();
   endfunction

   function automatic void put_image();
      logic [7:0] flags;
      gif_bytes.push_back(IMAGE_SEP);
      put_random(8);
      flags = pick_table_flags();
      gif_bytes.push_back(flags);
      put_color_table(flags);
      put_random(1);  // LZW code size, any value
      put_subblocks();
   endfunction

   function automatic logic [7:0] marker_like_byte();
      logic [7:0] picks [7] = '{EXT_INTRO, IMAGE_SEP, TRAILER, BLOCK_END,
                                LABEL_APP, LABEL_GFX_CTRL, LABEL_COMMENT};
      if ($urandom_range(7) == 0) return 8'($urandom);
      return picks[$urandom_range(6)];
   endfunction

   // Builds one file, possibly damaged; counted = bytes that will be sent for it.
   function automatic void build_gif_file(output int counted);
      logic [7:0] ver;
      logic [7:0] flags;
      int         pos;
      int         plan;
      gif_bytes.delete();
      label_spots.delete();
      size_spots.delete();
      ver = $urandom_range(1) ? VER_89 : VER_87;
      put_signature(ver, 6);
      put_random(4);
      flags = pick_table_flags();
      gif_bytes.push_back(flags);
      put_random(2);
      put_color_table(flags);
      if (ver == VER_87) put_image();
      else begin
         case (layout_type'($urandom_range(2)))
            LAYOUT_IMAGE_ONLY: put_image();
            LAYOUT_EXT_IMAGE: begin
               repeat ($urandom_range(1, 3)) put_extension();
               put_image();
            end
            default: begin
               put_app_extension();
               repeat ($urandom_range(3)) begin
                  repeat ($urandom_range(1, 2)) put_extension();
                  put_image();
               end
            end
         endcase
      end
      gif_bytes.push_back(TRAILER);

      pos  = -1;
      plan = $urandom_range(99);
      if (plan < 50) begin
      end else if (plan < 60) begin
         pos = $urandom_range(gif_bytes.size() - 1);
         gif_bytes[pos] = marker_like_byte();
      end else if (plan < 68 && label_spots.size() != 0) begin
         pos = label_spots[$urandom_range(label_spots.size() - 1)];
         gif_bytes[pos] = marker_like_byte();
      end else if (plan < 76 && size_spots.size() != 0) begin
         pos = size_spots[$urandom_range(size_spots.size() - 1)];
         gif_bytes[pos] = 8'($urandom);
      end else if (plan < 84) begin
         // early end
         pos = $urandom_range(1, gif_bytes.size() - 1);
         while (gif_bytes.size() > pos) void'(gif_bytes.pop_back());
         pos = -1;
      end else if (plan < 92) begin
         put_random($urandom_range(1, 3));
      end else begin
         pos = gif_bytes.size() - 1;
         gif_bytes[pos] = marker_like_byte();
      end
      counted = gif_bytes.size();
   endfunction

   // ---------------- channel driving ----------------

   task automatic send_byte(input logic [7:0] b, input logic fin);
      gsv_req_type item;
      item.data_byte = b;
      item.last_byte = fin;
      while (idle_on && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_file();
      foreach (gif_bytes[i]) send_byte(gif_bytes[i], i == gif_bytes.size() - 1);
   endtask

   task automatic wait_for_results();
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // result side: random stalls, plus one long hold-off so the input backs up
   initial begin : result_sink
      int cycle_no;
      cycle_no  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) cycle_no++;
         if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES) rsp_ready <= 1'b0;
         else if (idle_on) rsp_ready <= ($urandom_range(99) >= 11);
         else rsp_ready <= 1'b1;
      end
   end

   initial begin : byte_source
      int   random_items;
      int   file_items;
      logic drained;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      idle_on      = 1'b1;
      random_items = 0;
      drained      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // short directed files: byte extremes, signature faults, early ends
      gif_bytes = '{8'h00};
      send_file();
      gif_bytes = '{8'hff};
      send_file();
      gif_bytes.delete();
      put_signature(VER_89, 5);
      send_file();
      gif_bytes.delete();
      put_signature(VER_87, 4);
      gif_bytes.push_back(8'h78);  // bad version digit, then ignored bytes
      put_random(2);
      send_file();
      gif_bytes.delete();
      put_signature(VER_87, 6);
      send_file();

      while (random_items < RANDOM_ITEMS) begin
         build_gif_file(file_items);
         send_file();
         random_items += file_items;
         if (!drained && random_items >= 650) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            wait_for_results();
         end
         // a long stretch with no idling on either side
         if (random_items >= 400 && random_items < 850) idle_on <= 1'b0;
         else idle_on <= 1'b1;
      end

      req_valid <= 1'b0;
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
design/gsv_pkg.sv
design/gsv_parser.sv
design/gif_structure_validator.sv
design/gsv_checker.sv
tb/gif_format_pkg.sv
tb/gsv_checker.sv
tb/gif_structure_validator_tb.sv
